>>> hw/rtl/ucfc_pkg.sv
// ----------------------------------------------------------------------------
// ucfc_pkg
// Shared types and constants for the UART command frame checker.
// ----------------------------------------------------------------------------
package ucfc_pkg;

  localparam int unsigned TIME_BITS = 32;

  localparam logic [7:0]  HDR_BYTE  = 8'hAA;
  localparam logic [7:0]  END_BYTE  = 8'hBB;
  localparam logic [15:0] GAP_RESET = 16'd400;
  localparam logic [7:0]  MIN_LEN   = 8'd2;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_END   = 3'd1,
    ST_BAD_CHECK = 3'd2,
    ST_TOO_FREQ  = 3'd3,
    ST_BAD_LEN   = 3'd4
  } status_t;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_LEN   = 6'b000010,
    PH_CMD   = 6'b000100,
    PH_PARAM = 6'b001000,
    PH_CHECK = 6'b010000,
    PH_END   = 6'b100000
  } phase_t;

  // registered input word handed to the parser
  typedef struct packed {
    logic        vld;
    logic [7:0]  rx_byte;
    logic [31:0] arrival_ms;
  } in_word_t;

endpackage

>>> hw/rtl/ucfc_in_stage.sv
// ----------------------------------------------------------------------------
// ucfc_in_stage
// Input register: holds one received word until the parser takes it.
// ----------------------------------------------------------------------------
module ucfc_in_stage import ucfc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic [31:0] in_arrival_ms,
  input  logic        take,
  output in_word_t    word
);

  logic        vld_r,  vld_nxt;
  logic [7:0]  byte_r;
  logic [31:0] time_r;

  assign in_ready = !vld_r || take;

  always_comb begin
    vld_nxt = vld_r;
    if (take)
      vld_nxt = 1'b0;
    if (in_valid && in_ready)
      vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
      time_r <= in_arrival_ms;
    end
  end

  assign word.vld        = vld_r;
  assign word.rx_byte    = byte_r;
  assign word.arrival_ms = time_r;

endmodule

>>> hw/rtl/ucfc_parser.sv
// ----------------------------------------------------------------------------
// ucfc_parser
// Frame state machine with running XOR, header timing and result register.
// ----------------------------------------------------------------------------
module ucfc_parser import ucfc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  in_word_t    word,
  output logic        take,
  input  logic [15:0] min_gap_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [7:0]  out_command
);

  phase_t                phase_r,  phase_nxt;
  logic [7:0]            left_r,   left_nxt;
  logic [7:0]            xor_r,    xor_nxt;
  logic [7:0]            chk_r,    chk_nxt;
  logic [7:0]            cmd_r,    cmd_nxt;
  logic                  soon_r,   soon_nxt;
  logic [TIME_BITS-1:0]  last_r,   last_nxt;
  logic                  res_vld_r, res_vld_nxt;
  logic [2:0]            status_r;
  logic [7:0]            command_r;

  logic                  emit;
  status_t               emit_status;
  logic [7:0]            emit_cmd;
  logic [TIME_BITS-1:0]  now;
  logic [TIME_BITS-1:0]  diff;
  logic [7:0]            b;

  assign take = word.vld && (!res_vld_r || out_ready);
  assign b    = word.rx_byte;
  assign now  = TIME_BITS'(word.arrival_ms);
  assign diff = now - last_r;

  always_comb begin
    phase_nxt   = phase_r;
    left_nxt    = left_r;
    xor_nxt     = xor_r;
    chk_nxt     = chk_r;
    cmd_nxt     = cmd_r;
    soon_nxt    = soon_r;
    last_nxt    = last_r;
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_cmd    = 8'd0;
    case (phase_r)
      PH_LEN: begin
        if (b < MIN_LEN) begin
          emit        = 1'b1;
          emit_status = soon_r ? ST_TOO_FREQ : ST_BAD_LEN;
          phase_nxt   = PH_IDLE;
        end else begin
          xor_nxt   = b;
          left_nxt  = b - MIN_LEN;
          phase_nxt = PH_CMD;
        end
      end
      PH_CMD: begin
        cmd_nxt   = b;
        xor_nxt   = xor_r ^ b;
        phase_nxt = (left_r != 8'd0) ? PH_PARAM : PH_CHECK;
      end
      PH_PARAM: begin
        xor_nxt  = xor_r ^ b;
        left_nxt = left_r - 8'd1;
        if (left_r == 8'd1)
          phase_nxt = PH_CHECK;
      end
      PH_CHECK: begin
        chk_nxt   = b;
        phase_nxt = PH_END;
      end
      PH_END: begin
        emit      = 1'b1;
        phase_nxt = PH_IDLE;
        if (soon_r)
          emit_status = ST_TOO_FREQ;
        else if (b != END_BYTE)
          emit_status = ST_BAD_END;
        else if (chk_r != xor_r)
          emit_status = ST_BAD_CHECK;
        else begin
          emit_status = ST_OK;
          emit_cmd    = cmd_r;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (b == HDR_BYTE) begin
          soon_nxt  = diff < TIME_BITS'(min_gap_ms);
          last_nxt  = now;
          xor_nxt   = 8'd0;
          left_nxt  = 8'd0;
          chk_nxt   = 8'd0;
          cmd_nxt   = 8'd0;
          phase_nxt = PH_LEN;
        end
      end
    endcase
  end

  always_comb begin
    res_vld_nxt = res_vld_r;
    if (out_ready)
      res_vld_nxt = 1'b0;
    if (take && emit)
      res_vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      left_r    <= 8'd0;
      xor_r     <= 8'd0;
      chk_r     <= 8'd0;
      cmd_r     <= 8'd0;
      soon_r    <= 1'b0;
      last_r    <= '0;
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= res_vld_nxt;
      if (take) begin
        phase_r <= phase_nxt;
        left_r  <= left_nxt;
        xor_r   <= xor_nxt;
        chk_r   <= chk_nxt;
        cmd_r   <= cmd_nxt;
        soon_r  <= soon_nxt;
        last_r  <= last_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      status_r  <= emit_status;
      command_r <= emit_cmd;
    end
  end

  assign out_valid   = res_vld_r;
  assign out_status  = status_r;
  assign out_command = command_r;

endmodule

>>> hw/rtl/uart_command_frame_checker_core.sv
// ----------------------------------------------------------------------------
// uart_command_frame_checker_core
// Checks AA / L / CMD / params / XOR / BB command frames byte by byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one received byte per word with
//   its millisecond timestamp. Result channel (out_valid/out_ready) gives
//   one word per frame: status and, when accepted, the command byte.
//   cfg_we/cfg_wdata set min_gap_ms (reset 400); write only while idle.
// Timing:
//   A byte is registered in the input register; when the parser takes it,
//   the frame state machine updates; on the frame's last byte the result
//   register loads and raises out_valid. One byte per cycle sustained while
//   no result waits on out_ready; the per-byte parser update sets that rate.
// Reset:
//   Synchronous, active low. Parser returns to header hunting, the last
//   header time and all frame state clear to zero.
// Stall:
//   While a result waits on out_ready the parser holds; the input register
//   takes one more byte and then in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module uart_command_frame_checker_core import ucfc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic [31:0] in_arrival_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [7:0]  out_command,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic [15:0] min_gap_r;
  in_word_t    word;
  logic        take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_gap_r <= GAP_RESET;
    end else if (cfg_we) begin
      min_gap_r <= cfg_wdata;
    end
  end

  ucfc_in_stage u_in (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_rx_byte    (in_rx_byte),
    .in_arrival_ms (in_arrival_ms),
    .take          (take),
    .word          (word)
  );

  ucfc_parser u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .word        (word),
    .take        (take),
    .min_gap_ms  (min_gap_r),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status),
    .out_command (out_command)
  );

endmodule
